// ----- sv/tdrr_pkg.sv -----
package tdrr_pkg;

  localparam int TASK_SLOTS_DEF = 8;
  localparam logic [15:0] LOAD_WINDOW_RST = 16'd1000;

  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_DELAY  = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_YIELD  = 2'd3
  } action_t;

  typedef enum logic [0:0] {
    CFG_LOAD_WINDOW = 1'b0,
    CFG_HOLD        = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CREATE,
    ST_DLY_RM,
    ST_DLY_APP,
    ST_TICK_ACC,
    ST_REL_LOOK,
    ST_REL_RM,
    ST_REL_APP,
    ST_SCHED_START,
    ST_SCHED_WALK,
    ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic create;
    logic dly_rm;
    logic dly_app;
    logic tick_acc;
    logic rel_look;
    logic rel_rm;
    logic rel_app;
    logic rel_adv;
    logic sched_start;
    logic sched_step;
    logic sched_commit;
    logic set_err;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cur_none;
    logic cur_delayed;
    logic wait_zero;
    logic rel_more;
    logic rel_due;
    logic walk_stop;
  } dp_sts_t;

endpackage

// ----- sv/tdrr_if.sv -----
interface tdrr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  priority_req;
  logic        is_idle_task;
  logic [31:0] wait_ticks;
  modport source (output valid, action, priority_req, is_idle_task, wait_ticks, input ready);
  modport sink   (input valid, action, priority_req, is_idle_task, wait_ticks, output ready);
endinterface

interface tdrr_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  current_task;
  logic [2:0]  new_slot;
  logic        create_ok;
  logic [3:0]  task_count;
  logic [31:0] tick_count;
  logic [15:0] last_idle_ticks;
  logic        error;
  modport source (output valid, current_task, new_slot, create_ok, task_count, tick_count,
                  last_idle_ticks, error, input ready);
  modport sink   (input valid, current_task, new_slot, create_ok, task_count, tick_count,
                  last_idle_ticks, error, output ready);
endinterface

// ----- sv/tdrr_ctrl.sv -----
module tdrr_ctrl
  import tdrr_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_action,
  input  logic          hold,
  output logic          out_valid,
  input  logic          out_ready,
  output dp_cmd_t       cmd,
  input  dp_sts_t       sts
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          unique case (action_t'(in_action))
            ACT_CREATE: state_nxt = ST_CREATE;
            ACT_DELAY:  state_nxt = ST_DLY_RM;
            ACT_TICK:   state_nxt = hold ? ST_OUT : ST_TICK_ACC;
            ACT_YIELD:  state_nxt = hold ? ST_OUT : ST_SCHED_START;
          endcase
        end
      end
      ST_CREATE: begin
        cmd.create = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_DLY_RM: begin
        if (sts.wait_zero) state_nxt = ST_OUT;
        else if (sts.cur_none) begin
          cmd.set_err = 1'b1;
          state_nxt   = ST_OUT;
        end else if (sts.cur_delayed) state_nxt = ST_OUT;
        else begin
          cmd.dly_rm = 1'b1;
          state_nxt  = ST_DLY_APP;
        end
      end
      ST_DLY_APP: begin
        cmd.dly_app = 1'b1;
        state_nxt   = hold ? ST_OUT : ST_SCHED_START;
      end
      ST_TICK_ACC: begin
        cmd.tick_acc = 1'b1;
        state_nxt    = ST_REL_LOOK;
      end
      ST_REL_LOOK: begin
        if (sts.rel_more) begin
          cmd.rel_look = 1'b1;
          state_nxt    = ST_REL_RM;
        end else state_nxt = ST_SCHED_START;
      end
      ST_REL_RM: begin
        if (sts.rel_due) begin
          cmd.rel_rm = 1'b1;
          state_nxt  = ST_REL_APP;
        end else begin
          cmd.rel_adv = 1'b1;
          state_nxt   = ST_REL_LOOK;
        end
      end
      ST_REL_APP: begin
        cmd.rel_app = 1'b1;
        cmd.rel_adv = 1'b1;
        state_nxt   = ST_REL_LOOK;
      end
      ST_SCHED_START: begin
        cmd.sched_start = 1'b1;
        state_nxt       = ST_SCHED_WALK;
      end
      ST_SCHED_WALK: begin
        if (sts.walk_stop) begin
          cmd.sched_commit = 1'b1;
          state_nxt        = ST_OUT;
        end else cmd.sched_step = 1'b1;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == ST_OUT) else $error("out_valid outside output state");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("accept while result pending");
  a_capture_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> in_valid && in_ready) else $error("capture without accept");

endmodule

// ----- sv/tdrr_dp.sv -----
module tdrr_dp
  import tdrr_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF,
  parameter int IW = $clog2(TASK_SLOTS),
  parameter int PW = IW + 1
)(
  input  logic            clk,
  input  logic            rst_n,
  input  logic [15:0]     load_window,
  input  logic [7:0]      in_priority,
  input  logic            in_idle,
  input  logic [31:0]     in_wait,
  input  dp_cmd_t         cmd,
  output dp_sts_t         sts,
  output logic [PW-1:0]   current_task,
  output logic [IW-1:0]   new_slot,
  output logic            create_ok,
  output logic [PW-1:0]   task_count,
  output logic [31:0]     tick_count,
  output logic [15:0]     last_idle_ticks,
  output logic            error
);

  localparam logic [PW-1:0] NIL = PW'(TASK_SLOTS);

  logic [TASK_SLOTS-1:0] used_r, indly_r;
  logic [7:0]    prio_r [TASK_SLOTS];
  logic [31:0]   rel_r  [TASK_SLOTS];
  logic [PW-1:0] next_r [TASK_SLOTS];
  logic [PW-1:0] prev_r [TASK_SLOTS];
  logic [PW-1:0] rhead_r, rtail_r, dhead_r, dtail_r, cur_r, idle_r;
  logic [31:0]   ticks_r;
  logic [15:0]   win_r, icnt_r, ilast_r;
  logic [PW-1:0] cnt_r;
  logic [7:0]    prio_q;
  logic          idle_q;
  logic [31:0]   wait_q;
  logic [IW-1:0] nslot_r;
  logic          ok_r, err_r;
  logic [PW-1:0] walk_r, rnext_r;
  logic [PW-1:0] steps_r;
  logic [7:0]    cprio_r;

  // lowest free slot
  logic [IW-1:0] free_idx;
  logic          free_ok;
  always_comb begin
    free_idx = '0;
    free_ok  = 1'b0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_idx = IW'(i);
        free_ok  = 1'b1;
      end
    end
  end

  logic [IW-1:0] cur_i, walk_i;
  assign cur_i  = cur_r[IW-1:0];
  assign walk_i = walk_r[IW-1:0];

  // select the slot to unlink from and append to a list (head/tail passed via select)
  logic          rm_on, rm_dly, app_on, app_dly;
  logic [IW-1:0] rm_s, app_s;
  logic [PW-1:0] rm_p, rm_n, app_tail;
  always_comb begin
    rm_on   = cmd.dly_rm | cmd.rel_rm;
    rm_dly  = cmd.rel_rm;
    rm_s    = cmd.rel_rm ? walk_i : cur_i;
    rm_p    = prev_r[rm_s];
    rm_n    = next_r[rm_s];
    app_on  = cmd.create | cmd.dly_app | cmd.rel_app;
    app_dly = cmd.dly_app;
    app_s   = cmd.create ? free_idx : (cmd.rel_app ? walk_i : cur_i);
    app_tail = app_dly ? dtail_r : rtail_r;
  end

  assign sts.cur_none    = (cur_r == NIL);
  assign sts.cur_delayed = (cur_r != NIL) && indly_r[cur_i];
  assign sts.wait_zero   = (wait_q == '0);
  assign sts.rel_more    = (walk_r != NIL) && (steps_r < PW'(TASK_SLOTS));
  assign sts.rel_due     = (ticks_r >= rel_r[walk_i]);
  assign sts.walk_stop   = (walk_r == NIL) || (steps_r >= PW'(TASK_SLOTS)) ||
                           !(cprio_r > prio_r[walk_i]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      indly_r <= '0;
      rhead_r <= NIL; rtail_r <= NIL; dhead_r <= NIL; dtail_r <= NIL;
      cur_r   <= NIL; idle_r  <= NIL;
      ticks_r <= '0; win_r <= '0; icnt_r <= '0; ilast_r <= '0; cnt_r <= '0;
      ok_r <= 1'b0; err_r <= 1'b0; nslot_r <= '0;
    end else begin
      if (cmd.capture) begin
        ok_r <= 1'b0; err_r <= 1'b0; nslot_r <= '0;
      end
      if (cmd.set_err) err_r <= 1'b1;
      if (cmd.create && free_ok) begin
        used_r[free_idx]  <= 1'b1;
        indly_r[free_idx] <= 1'b0;
        prio_r[free_idx]  <= prio_q;
        cnt_r <= cnt_r + 1'b1;
        if (cur_r == NIL) cur_r <= PW'(free_idx);
        if (idle_q) idle_r <= PW'(free_idx);
        nslot_r <= free_idx;
        ok_r    <= 1'b1;
      end
      if (rm_on) begin
        if (rm_p != NIL) next_r[rm_p[IW-1:0]] <= rm_n;
        else if (rm_dly) dhead_r <= rm_n;
        else rhead_r <= rm_n;
        if (rm_n != NIL) prev_r[rm_n[IW-1:0]] <= rm_p;
        else if (rm_dly) dtail_r <= rm_p;
        else rtail_r <= rm_p;
      end
      if (app_on && !(cmd.create && !free_ok)) begin
        if (app_tail != NIL) next_r[app_tail[IW-1:0]] <= PW'(app_s);
        else if (app_dly) dhead_r <= PW'(app_s);
        else rhead_r <= PW'(app_s);
        prev_r[app_s] <= app_tail;
        next_r[app_s] <= NIL;
        if (app_dly) dtail_r <= PW'(app_s);
        else rtail_r <= PW'(app_s);
      end
      if (cmd.dly_rm) rel_r[cur_i] <= ticks_r + wait_q;
      if (cmd.dly_app) indly_r[cur_i] <= 1'b1;
      if (cmd.rel_rm) indly_r[walk_i] <= 1'b0;
      if (cmd.tick_acc) begin
        if (win_r >= load_window) begin
          win_r   <= '0;
          ilast_r <= (cur_r == idle_r) ? icnt_r + 1'b1 : icnt_r;
          icnt_r  <= '0;
        end else begin
          win_r <= win_r + 1'b1;
          if (cur_r == idle_r) icnt_r <= icnt_r + 1'b1;
        end
        ticks_r <= ticks_r + 1'b1;
        walk_r  <= dhead_r;
        steps_r <= '0;
      end
      if (cmd.rel_look) rnext_r <= next_r[walk_i];
      if (cmd.rel_adv) begin
        walk_r  <= rnext_r;
        steps_r <= steps_r + 1'b1;
      end
      if (cmd.sched_start) begin
        steps_r <= '0;
        if (cur_r != NIL && !indly_r[cur_i]) begin
          walk_r  <= next_r[cur_i];
          cprio_r <= prio_r[cur_i];
        end else walk_r <= NIL;
      end
      if (cmd.sched_step) begin
        walk_r  <= next_r[walk_i];
        steps_r <= steps_r + 1'b1;
      end
      if (cmd.sched_commit) cur_r <= (walk_r != NIL) ? walk_r : rhead_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      prio_q <= in_priority;
      idle_q <= in_idle;
      wait_q <= in_wait;
    end
  end

  assign current_task    = cur_r;
  assign new_slot        = nslot_r;
  assign create_ok       = ok_r;
  assign task_count      = cnt_r;
  assign tick_count      = ticks_r;
  assign last_idle_ticks = ilast_r;
  assign error           = err_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= PW'(TASK_SLOTS)) else $error("task count overflow");
  a_cnt_match: assert property (@(posedge clk) disable iff (!rst_n)
    PW'($countones(used_r)) == cnt_r) else $error("count mismatch");
  a_ok_err: assert property (@(posedge clk) disable iff (!rst_n)
    !(ok_r && err_r)) else $error("create ok with error");

endmodule

// ----- sv/tick_delay_round_robin_scheduler_top.sv -----
// Flow: create goes through the create state to the result; yield runs the schedule walk;
//   tick releases due delayed slots, then schedules; hold sends both straight to the result.
// Throughput: one item at a time; the schedule walk steps one slot per cycle.
// Reset: synchronous active-low rst_n empties both lists, clears counters, sets
//   load window 1000 and hold 0; slot tables are undefined until written.
module tick_delay_round_robin_scheduler_top
  import tdrr_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
)(
  input  logic         clk,
  input  logic         rst_n,
  tdrr_in_if.sink      in_ch,
  tdrr_out_if.source   out_ch,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  localparam int IW = $clog2(TASK_SLOTS);
  localparam int PW = IW + 1;

  logic [15:0] load_window_r;
  logic        hold_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_window_r <= LOAD_WINDOW_RST;
      hold_r        <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LOAD_WINDOW: load_window_r <= cfg_data;
        CFG_HOLD:        hold_r        <= cfg_data[0];
      endcase
    end
  end

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [PW-1:0] cur_w, cnt_w;
  logic [IW-1:0] nslot_w;

  tdrr_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_action(in_ch.action),
    .hold     (hold_r),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .cmd, .sts
  );

  tdrr_dp #(.TASK_SLOTS(TASK_SLOTS)) u_dp (
    .clk, .rst_n,
    .load_window    (load_window_r),
    .in_priority    (in_ch.priority_req),
    .in_idle        (in_ch.is_idle_task),
    .in_wait        (in_ch.wait_ticks),
    .cmd, .sts,
    .current_task   (cur_w),
    .new_slot       (nslot_w),
    .create_ok      (out_ch.create_ok),
    .task_count     (cnt_w),
    .tick_count     (out_ch.tick_count),
    .last_idle_ticks(out_ch.last_idle_ticks),
    .error          (out_ch.error)
  );

  assign out_ch.current_task = 4'(cur_w);
  assign out_ch.task_count   = 4'(cnt_w);
  assign out_ch.new_slot     = 3'(nslot_w);

endmodule
